### sv/mfse_pkg.sv
// ----------------------------------------------------------------------------
// mfse_pkg
// Shared types, constants and a lookup function of the sysex extractor.
// ----------------------------------------------------------------------------
package mfse_pkg;

    localparam int COUNT_BITS = 32;

    typedef logic [COUNT_BITS-1:0] count_t;

    typedef enum logic [3:0] {
        PH_START  = 4'd0,
        PH_HMAGIC = 4'd1,
        PH_HLEN   = 4'd2,
        PH_HSKIP  = 4'd3,
        PH_TMAGIC = 4'd4,
        PH_TLEN   = 4'd5,
        PH_DELTA  = 4'd6,
        PH_STATUS = 4'd7,
        PH_MTYPE  = 4'd8,
        PH_VLEN   = 4'd9,
        PH_SKIP   = 4'd10,
        PH_SXDATA = 4'd11,
        PH_RSCAN  = 4'd12,
        PH_RMSG   = 4'd13,
        PH_DONE   = 4'd14
    } phase_t;

    localparam logic [7:0] SYSEX_START = 8'hF0;
    localparam logic [7:0] SYSEX_END   = 8'hF7;
    localparam logic [7:0] META_EVENT  = 8'hFF;
    localparam logic [7:0] DATA_MASK   = 8'h7F;
    localparam logic [7:0] STATUS_BIT  = 8'h80;

    // status nibbles
    localparam logic [3:0] NIB_NOTE_OFF  = 4'h8;
    localparam logic [3:0] NIB_NOTE_ON   = 4'h9;
    localparam logic [3:0] NIB_POLY_AT   = 4'hA;
    localparam logic [3:0] NIB_CTRL      = 4'hB;
    localparam logic [3:0] NIB_PROG      = 4'hC;
    localparam logic [3:0] NIB_CHAN_AT   = 4'hD;
    localparam logic [3:0] NIB_PITCH     = 4'hE;
    localparam logic [3:0] NIB_SYSTEM    = 4'hF;

    localparam logic [7:0] SYS_MTC       = 8'hF1;
    localparam logic [7:0] SYS_SONG_POS  = 8'hF2;
    localparam logic [7:0] SYS_SONG_SEL  = 8'hF3;

    localparam logic [2:0] MAGIC_LAST    = 3'd3;

    // tuser bit positions of the result side
    localparam int USER_BYTE_VALID = 0;
    localparam int USER_UNTERM     = 1;
    localparam int USER_HDR_ERROR  = 2;
    localparam int USER_BITS       = 3;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] msg_byte;
        logic       msg_last;
        logic       unterminated;
        logic       header_error;
    } result_t;

    // "MThd" and "MTrk"
    function automatic logic [7:0] magic_byte(input logic is_track, input logic [1:0] idx);
        logic [7:0] val;
        case (idx)
            2'd0: val = 8'h4D;
            2'd1: val = 8'h54;
            2'd2: val = is_track ? 8'h72 : 8'h68;
            2'd3: val = is_track ? 8'h6B : 8'h64;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

### sv/mfse_parser.sv
// ----------------------------------------------------------------------------
// mfse_parser
// Parser state and per-byte next-state logic for the sysex extractor.
// ----------------------------------------------------------------------------
module mfse_parser
    import mfse_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] in_byte,
    input  logic       file_start,
    input  logic       file_end,
    input  logic       file_format,
    output logic       emit,
    output result_t    result
);

    phase_t      phase_reg, phase_next;
    count_t      track_reg, track_next;
    count_t      skip_reg, skip_next;
    logic [31:0] accum_reg, accum_next;
    logic [7:0]  rstat_reg, rstat_next;
    logic [7:0]  ccmd_reg, ccmd_next;
    logic [2:0]  hbc_reg, hbc_next;
    count_t      sysex_reg, sysex_next;

    logic        do_end;
    logic        do_skip;
    count_t      skip_len;
    logic [7:0]  cmd;
    logic        first;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            track_reg <= '0;
            skip_reg  <= '0;
            accum_reg <= '0;
            rstat_reg <= '0;
            ccmd_reg  <= '0;
            hbc_reg   <= '0;
            sysex_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            track_reg <= track_next;
            skip_reg  <= skip_next;
            accum_reg <= accum_next;
            rstat_reg <= rstat_next;
            ccmd_reg  <= ccmd_next;
            hbc_reg   <= hbc_next;
            sysex_reg <= sysex_next;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        track_next = track_reg;
        skip_next  = skip_reg;
        accum_next = accum_reg;
        rstat_next = rstat_reg;
        ccmd_next  = ccmd_reg;
        hbc_next   = hbc_reg;
        sysex_next = sysex_reg;
        do_end     = 1'b0;
        do_skip    = 1'b0;
        skip_len   = '0;
        cmd        = '0;
        first      = 1'b0;
        emit       = 1'b0;
        result     = '0;

        if (file_start)
        begin
            phase_next = PH_START;
            track_next = '0;
            skip_next  = '0;
            accum_next = '0;
            rstat_next = '0;
            ccmd_next  = '0;
            hbc_next   = '0;
            sysex_next = '0;
        end
        if (phase_next == PH_START)
        begin
            phase_next = file_format ? PH_RSCAN : PH_HMAGIC;
            hbc_next   = '0;
        end
        // every byte inside the track body counts the track down
        if (phase_next >= PH_DELTA && phase_next <= PH_SXDATA && track_next != '0)
            track_next = track_next - 1'b1;

        case (phase_next)
            PH_HMAGIC, PH_TMAGIC:
            begin
                if (in_byte != magic_byte(phase_next == PH_TMAGIC, hbc_next[1:0]))
                begin
                    emit                = 1'b1;
                    result.header_error = 1'b1;
                    phase_next          = PH_DONE;
                end
                else if (hbc_next == MAGIC_LAST)
                begin
                    hbc_next   = '0;
                    accum_next = '0;
                    phase_next = (phase_next == PH_HMAGIC) ? PH_HLEN : PH_TLEN;
                end
                else
                    hbc_next = hbc_next + 3'd1;
            end
            PH_HLEN, PH_TLEN:
            begin
                accum_next = {accum_next[23:0], in_byte};
                if (hbc_next == MAGIC_LAST)
                begin
                    hbc_next = '0;
                    if (phase_next == PH_HLEN)
                    begin
                        skip_next  = accum_next[COUNT_BITS-1:0];
                        phase_next = (skip_next == '0) ? PH_TMAGIC : PH_HSKIP;
                    end
                    else
                    begin
                        track_next = accum_next[COUNT_BITS-1:0];
                        do_end     = 1'b1;
                    end
                end
                else
                    hbc_next = hbc_next + 3'd1;
            end
            PH_HSKIP:
            begin
                if (skip_next != '0)
                    skip_next = skip_next - 1'b1;
                if (skip_next == '0)
                begin
                    phase_next = PH_TMAGIC;
                    hbc_next   = '0;
                end
            end
            PH_DELTA:
            begin
                if ((in_byte & STATUS_BIT) == '0)
                    phase_next = PH_STATUS;
            end
            PH_STATUS:
            begin
                if (in_byte == META_EVENT)
                begin
                    ccmd_next  = META_EVENT;
                    phase_next = PH_MTYPE;
                end
                else
                begin
                    cmd = rstat_next;
                    if ((in_byte & STATUS_BIT) != '0)
                    begin
                        cmd = in_byte;
                        if (in_byte < SYSEX_START)
                        begin
                            rstat_next = in_byte;
                            first      = 1'b1;
                        end
                    end
                    ccmd_next = cmd;
                    do_skip   = 1'b1;
                    case (cmd[7:4])
                        NIB_NOTE_OFF, NIB_NOTE_ON, NIB_POLY_AT, NIB_CTRL, NIB_PITCH:
                            skip_len = count_t'(first) + count_t'(1);
                        NIB_PROG, NIB_CHAN_AT:
                            skip_len = count_t'(first);
                        NIB_SYSTEM:
                        begin
                            if (cmd == SYSEX_START || cmd == SYSEX_END)
                            begin
                                accum_next = '0;
                                phase_next = PH_VLEN;
                                do_skip    = 1'b0;
                            end
                            else if (cmd == SYS_MTC || cmd == SYS_SONG_SEL)
                                skip_len = count_t'(1);
                            else if (cmd == SYS_SONG_POS)
                                skip_len = count_t'(2);
                            else
                                skip_len = '0;
                        end
                        // data byte without any running status
                        default: skip_len = '0;
                    endcase
                end
            end
            PH_MTYPE:
            begin
                accum_next = '0;
                phase_next = PH_VLEN;
            end
            PH_VLEN:
            begin
                accum_next = {accum_next[24:0], in_byte[6:0]};
                if ((in_byte & STATUS_BIT) == '0)
                begin
                    if (ccmd_next == META_EVENT)
                    begin
                        do_skip  = 1'b1;
                        skip_len = accum_next[COUNT_BITS-1:0];
                    end
                    else
                    begin
                        sysex_next = accum_next[COUNT_BITS-1:0];
                        if (sysex_next == '0)
                            do_end = 1'b1;
                        else
                            phase_next = PH_SXDATA;
                    end
                end
            end
            PH_SKIP:
            begin
                if (skip_next != '0)
                    skip_next = skip_next - 1'b1;
                if (skip_next == '0)
                    do_end = 1'b1;
            end
            PH_SXDATA:
            begin
                emit              = 1'b1;
                result.byte_valid = 1'b1;
                result.msg_byte   = in_byte;
                if (sysex_next != '0)
                    sysex_next = sysex_next - 1'b1;
                if (sysex_next == '0 || file_end)
                begin
                    result.msg_last     = 1'b1;
                    result.unterminated = (in_byte != SYSEX_END);
                    if (sysex_next == '0)
                        do_end = 1'b1;
                end
            end
            PH_RSCAN:
            begin
                if (in_byte == SYSEX_START)
                    phase_next = PH_RMSG;
            end
            PH_RMSG:
            begin
                emit              = 1'b1;
                result.byte_valid = 1'b1;
                result.msg_byte   = in_byte;
                if (in_byte == SYSEX_END)
                begin
                    result.msg_last = 1'b1;
                    phase_next      = PH_RSCAN;
                end
                else if (file_end)
                begin
                    result.msg_last     = 1'b1;
                    result.unterminated = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        if (do_skip)
        begin
            skip_next = skip_len;
            if (skip_len == '0)
                do_end = 1'b1;
            else
                phase_next = PH_SKIP;
        end
        // event done: next byte is a delta time, or a track magic once the track is used up
        if (do_end)
        begin
            if (track_next == '0)
            begin
                phase_next = PH_TMAGIC;
                hbc_next   = '0;
            end
            else
                phase_next = PH_DELTA;
        end
        if (file_end)
            phase_next = PH_DONE;
    end

endmodule

### sv/midi_file_sysex_extractor.sv
// ----------------------------------------------------------------------------
// midi_file_sysex_extractor
// Byte stream parser that pulls sysex messages out of a MIDI file or raw dump.
// ----------------------------------------------------------------------------
// path: input register, then combinational parser update, then output register on m_axis
// throughput: one byte per cycle unless m_axis stalls, set by the combinational parser update
//   between the input register and the output register
// reset: rst_n clears parser state, valid flags and file_format (standard file mode)
// bytes that yield no result leave no word on m_axis
module midi_file_sysex_extractor
    import mfse_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [7:0] in_byte
    input  logic                 s_axis_tlast,   // file_end
    input  logic                 s_axis_tuser,   // [0] file_start
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata,   // [7:0] msg_byte
    output logic                 m_axis_tlast,   // msg_last
    output logic [USER_BITS-1:0] m_axis_tuser,   // [0] byte_valid, [1] unterminated, [2] header_error
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_data        // file_format
);

    logic       fmt_reg;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_start_reg;
    logic       in_end_reg;
    logic       out_valid_reg;
    result_t    out_reg;

    logic       proc_ok;
    logic       step;
    logic       emit;
    result_t    result;

    assign proc_ok       = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && proc_ok;
    assign s_axis_tready = !in_valid_reg || proc_ok;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fmt_reg <= 1'b0;
        else if (cfg_valid)
            fmt_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                in_valid_reg <= 1'b1;
            else if (step)
                in_valid_reg <= 1'b0;
            if (step)
                out_valid_reg <= emit;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg  <= s_axis_tdata;
            in_start_reg <= s_axis_tuser;
            in_end_reg   <= s_axis_tlast;
        end
        if (step)
            out_reg <= result;
    end

    mfse_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .in_byte     (in_byte_reg),
        .file_start  (in_start_reg),
        .file_end    (in_end_reg),
        .file_format (fmt_reg),
        .emit        (emit),
        .result      (result)
    );

    assign m_axis_tvalid                = out_valid_reg;
    assign m_axis_tdata                 = out_reg.msg_byte;
    assign m_axis_tlast                 = out_reg.msg_last;
    assign m_axis_tuser[USER_BYTE_VALID] = out_reg.byte_valid;
    assign m_axis_tuser[USER_UNTERM]     = out_reg.unterminated;
    assign m_axis_tuser[USER_HDR_ERROR]  = out_reg.header_error;

endmodule

### sv/mfse_checker.sv
// ----------------------------------------------------------------------------
// mfse_checker
// Port-level checks of the sysex extractor, bound to the top level.
// ----------------------------------------------------------------------------
module mfse_checker
    import mfse_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [7:0]           m_axis_tdata,
    input logic                 m_axis_tlast,
    input logic [USER_BITS-1:0] m_axis_tuser
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // a header error word carries no message byte
    a_herr_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[USER_HDR_ERROR] |->
            !m_axis_tuser[USER_BYTE_VALID] && m_axis_tdata == '0 && !m_axis_tlast
            && !m_axis_tuser[USER_UNTERM])
        else $error("header error word carries payload");

    // the only word without a message byte is a header error
    a_novalid_is_herr: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[USER_BYTE_VALID] |->
            m_axis_tuser[USER_HDR_ERROR])
        else $error("empty word without header error");

    a_unterm_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[USER_UNTERM] |->
            m_axis_tlast && m_axis_tuser[USER_BYTE_VALID])
        else $error("unterminated flag off the last byte");

    // a properly closed message ends in F7
    a_term_f7: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast && !m_axis_tuser[USER_UNTERM] |->
            m_axis_tdata == SYSEX_END)
        else $error("terminated message does not end in F7");

endmodule

bind midi_file_sysex_extractor mfse_checker u_mfse_checker (.*);
